// ===== rtl/core/bsd_pkg.sv =====
// Shared result codes and the command format passed from parser to emitter.
`timescale 1ns / 1ps

package bsd_pkg;

    localparam logic [1:0] K_PIXEL  = 2'd0;
    localparam logic [1:0] K_HEADER = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;

    localparam logic [2:0] E_SHORT     = 3'd0;
    localparam logic [2:0] E_MAGIC     = 3'd1;
    localparam logic [2:0] E_DIB       = 3'd2;
    localparam logic [2:0] E_FORMAT    = 3'd3;
    localparam logic [2:0] E_PAST_END  = 3'd4;
    localparam logic [2:0] E_TOO_LARGE = 3'd5;
    localparam logic [2:0] E_OFFSET    = 3'd6;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [12:0] width;
        logic [12:0] height;
        logic [11:0] x;
        logic [11:0] row;
        logic [23:0] rgb;
        logic        last;
        logic        top;
    } t_cmd;

endpackage

// ===== rtl/core/bsd_front.sv =====
// Byte parser: header fields and checks, pixel assembly and position tracking.
`timescale 1ns / 1ps

module bsd_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output bsd_pkg::t_cmd o_cmd
);
    import bsd_pkg::*;

    localparam int W   = $clog2(MAX_DIM + 1);
    localparam int CW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int RBW = W + 2;
    localparam int PW  = RBW + W;
    localparam int NW  = ((PW > 32) ? PW : 32) + 1;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_GAP     = 3'd1;
    localparam logic [2:0] PH_PIXELS  = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_SWALLOW = 3'd4;

    localparam logic [7:0] MAGIC_B = 8'h42;
    localparam logic [7:0] MAGIC_M = 8'h4D;

    logic [31:0]     r_flen;
    logic [31:0]     r_pos;
    logic [2:0]      r_phase;
    logic [31:0]     r_offset;
    logic [31:0]     r_dib;
    logic [31:0]     r_width;
    logic [31:0]     r_height;
    logic [15:0]     r_planes;
    logic [15:0]     r_bpp;
    logic            r_comp_nz;
    logic [31:0]     r_habs;
    logic [RBW-1:0]  r_rowb;
    logic [PW-1:0]   r_prod;
    logic [NW-1:0]   r_need;
    logic            r_fmt_bad;
    logic            r_big;
    logic            r_off_bad;
    logic [W-1:0]    r_wdim;
    logic [W-1:0]    r_hdim;
    logic            r_top;
    logic            r_four;
    logic [CW-1:0]   r_col;
    logic [CW-1:0]   r_row;
    logic [1:0]      r_bip;
    logic [23:0]     r_pix;
    logic [1:0]      r_pad;

    logic [31:0]     n_pos;
    logic [2:0]      n_phase;
    logic [CW-1:0]   n_col;
    logic [CW-1:0]   n_row;
    logic [1:0]      n_bip;
    logic [1:0]      n_pad;

    logic [2:0]      w_ph;
    logic [1:0]      w_lane;
    logic [31:0]     w_dib_full;
    logic            w_file_end;
    logic            w_bip_done;
    logic [W-1:0]    w_col_next;
    logic [W-1:0]    w_row_next;
    logic            w_last;
    logic [23:0]     w_rgb;
    logic            w_hdr_bad;
    logic [2:0]      w_hdr_code;
    logic [31:0]     w_col32;
    logic [31:0]     w_row32;
    logic [31:0]     w_wdim32;
    logic [RBW-1:0]  w_wc;
    logic [RBW-1:0]  w_rb_raw;
    logic [RBW-1:0]  w_rowb;
    t_cmd            w_cmd;
    logic            w_emit;

    assign w_lane     = r_pos[1:0] + 2'd2;
    assign w_dib_full = {i_byte, r_dib[23:0]};
    assign w_file_end = ({1'b0, r_pos} + 33'd1) >= {1'b0, r_flen};
    assign w_ph       = (r_phase == PH_GAP && r_pos >= r_offset) ? PH_PIXELS : r_phase;
    assign w_bip_done = r_four ? (r_bip == 2'd3) : (r_bip == 2'd2);
    assign w_col_next = W'(r_col) + W'(1);
    assign w_row_next = W'(r_row) + W'(1);
    assign w_last     = (w_row_next == r_hdim) && (w_col_next == r_wdim);
    assign w_rgb      = r_four ? r_pix : {i_byte, r_pix[15:0]};
    assign w_col32    = 32'(r_col);
    assign w_row32    = 32'(r_row);
    assign w_wdim32   = 32'(r_wdim);

    assign w_wc     = RBW'(r_width[W-1:0]);
    assign w_rb_raw = (r_bpp == 16'd32) ? (w_wc << 2) : ((w_wc << 1) + w_wc);
    assign w_rowb   = (w_rb_raw + RBW'(3)) & ~RBW'(3);

    always_comb begin
        w_hdr_bad  = 1'b1;
        w_hdr_code = E_FORMAT;
        priority if (r_fmt_bad || i_byte != 8'd0) begin
            w_hdr_code = E_FORMAT;
        end else if (r_big) begin
            w_hdr_code = E_TOO_LARGE;
        end else if (NW'(r_flen) < r_need) begin
            w_hdr_code = E_PAST_END;
        end else if (r_off_bad) begin
            w_hdr_code = E_OFFSET;
        end else begin
            w_hdr_bad = 1'b0;
        end
    end

    always_comb begin
        w_cmd   = '0;
        w_emit  = 1'b0;
        n_phase = w_ph;
        n_col   = r_col;
        n_row   = r_row;
        n_bip   = r_bip;
        n_pad   = r_pad;
        unique case (w_ph)
            PH_HEADER: begin
                priority if (r_pos == 32'd0) begin
                    if (r_flen < 32'd54) begin
                        w_emit     = 1'b1;
                        w_cmd.kind = K_ERROR;
                        w_cmd.code = E_SHORT;
                        n_phase    = PH_SWALLOW;
                    end else if (i_byte != MAGIC_B) begin
                        w_emit     = 1'b1;
                        w_cmd.kind = K_ERROR;
                        w_cmd.code = E_MAGIC;
                        n_phase    = PH_SWALLOW;
                    end
                end else if (r_pos == 32'd1) begin
                    if (i_byte != MAGIC_M) begin
                        w_emit     = 1'b1;
                        w_cmd.kind = K_ERROR;
                        w_cmd.code = E_MAGIC;
                        n_phase    = PH_SWALLOW;
                    end
                end else if (r_pos == 32'd17) begin
                    if (w_dib_full < 32'd40 ||
                        {1'b0, r_flen} < 33'd14 + {1'b0, w_dib_full}) begin
                        w_emit     = 1'b1;
                        w_cmd.kind = K_ERROR;
                        w_cmd.code = E_DIB;
                        n_phase    = PH_SWALLOW;
                    end
                end else if (r_pos == 32'd33) begin
                    w_emit = 1'b1;
                    if (w_hdr_bad) begin
                        w_cmd.kind = K_ERROR;
                        w_cmd.code = w_hdr_code;
                        n_phase    = PH_SWALLOW;
                    end else begin
                        w_cmd.kind   = K_HEADER;
                        w_cmd.width  = r_width[12:0];
                        w_cmd.height = r_habs[12:0];
                        w_cmd.top    = r_height[31];
                        n_phase      = PH_GAP;
                        n_col        = '0;
                        n_row        = '0;
                        n_bip        = '0;
                    end
                end else begin
                    n_phase = PH_HEADER;
                end
            end
            PH_PIXELS: begin
                n_bip = r_bip + 2'd1;
                if (w_bip_done) begin
                    w_emit     = 1'b1;
                    w_cmd.kind = K_PIXEL;
                    w_cmd.x    = w_col32[11:0];
                    w_cmd.row  = w_row32[11:0];
                    w_cmd.rgb  = w_rgb;
                    w_cmd.last = w_last;
                    n_bip      = '0;
                    if (w_last) begin
                        n_phase = PH_SWALLOW;
                    end else if (w_col_next == r_wdim) begin
                        n_col = '0;
                        n_row = CW'(w_row_next);
                        if (!r_four && w_wdim32[1:0] != 2'd0) begin
                            n_pad   = w_wdim32[1:0];
                            n_phase = PH_PAD;
                        end
                    end else begin
                        n_col = CW'(w_col_next);
                    end
                end
            end
            PH_PAD: begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end
                if (r_pad <= 2'd1) begin
                    n_phase = PH_PIXELS;
                end
            end
            default: begin
                n_phase = w_ph;
            end
        endcase
        if (w_file_end) begin
            n_phase = PH_HEADER;
            n_pos   = '0;
        end else begin
            n_pos = r_pos + 32'd1;
        end
    end

    assign o_push = i_accept && w_emit;
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen  <= '0;
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_col   <= '0;
            r_row   <= '0;
            r_bip   <= '0;
            r_pad   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_flen <= i_cfg_data;
            end
            if (i_accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_col   <= n_col;
                r_row   <= n_row;
                r_bip   <= n_bip;
                r_pad   <= n_pad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_ph == PH_HEADER) begin
            if (r_pos >= 32'd10 && r_pos <= 32'd13) r_offset[8*w_lane +: 8] <= i_byte;
            if (r_pos >= 32'd14 && r_pos <= 32'd17) r_dib[8*w_lane +: 8] <= i_byte;
            if (r_pos >= 32'd18 && r_pos <= 32'd21) r_width[8*w_lane +: 8] <= i_byte;
            if (r_pos >= 32'd22 && r_pos <= 32'd25) r_height[8*w_lane +: 8] <= i_byte;
            if (r_pos >= 32'd26 && r_pos <= 32'd27) r_planes[8*r_pos[0] +: 8] <= i_byte;
            if (r_pos >= 32'd28 && r_pos <= 32'd29) r_bpp[8*r_pos[0] +: 8] <= i_byte;
            if (r_pos == 32'd26) begin
                r_habs <= r_height[31] ? (32'd0 - r_height) : r_height;
            end
            if (r_pos == 32'd30) begin
                r_comp_nz <= (i_byte != 8'd0);
                r_rowb    <= w_rowb;
            end
            if (r_pos == 32'd31) begin
                r_comp_nz <= r_comp_nz || (i_byte != 8'd0);
                r_prod    <= PW'(r_rowb) * PW'(r_habs[W-1:0]);
            end
            if (r_pos == 32'd32) begin
                r_need    <= NW'(r_offset) + NW'(r_prod);
                r_fmt_bad <= r_planes != 16'd1 || (r_bpp != 16'd24 && r_bpp != 16'd32) ||
                             r_width == 32'd0 || r_width[31] ||
                             r_habs == 32'd0 || r_habs[31] ||
                             r_comp_nz || i_byte != 8'd0;
                r_big     <= r_width > 32'(MAX_DIM) || r_habs > 32'(MAX_DIM);
                r_off_bad <= {1'b0, r_offset} < 33'd14 + {1'b0, r_dib};
            end
            if (r_pos == 32'd33) begin
                r_wdim <= r_width[W-1:0];
                r_hdim <= r_habs[W-1:0];
                r_top  <= r_height[31];
                r_four <= (r_bpp == 16'd32);
            end
        end
        if (i_accept && w_ph == PH_PIXELS && r_bip != 2'd3) begin
            r_pix[8*r_bip +: 8] <= i_byte;
        end
    end

endmodule

// ===== rtl/core/bsd_queue.sv =====
// Short command queue between the parser and the result emitter.
`timescale 1ns / 1ps

module bsd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bsd_pkg::t_cmd o_cmd
);
    import bsd_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_push_ok;
    logic                w_pop_ok;

    assign o_full    = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_cmd     = r_slot[r_rd];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({w_push_ok, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/bsd_back.sv =====
// Result emitter: row flip, field packing and the output register.
`timescale 1ns / 1ps

module bsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bsd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [79:0]   o_m_tdata,
    output logic [1:0]    o_m_tuser,
    output logic          o_m_tlast
);
    import bsd_pkg::*;

    logic [11:0] r_h;
    logic        r_top;
    logic        r_valid;
    logic [79:0] r_data;
    logic [1:0]  r_user;
    logic        r_last;
    logic        w_load;
    logic [11:0] w_y;

    assign w_load = i_valid && (!r_valid || i_m_tready);
    assign o_pop  = w_load;

    always_comb begin
        w_y = 12'd0;
        if (i_cmd.kind == K_PIXEL) begin
            w_y = r_top ? i_cmd.row : (r_h - 12'd1 - i_cmd.row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_top   <= 1'b0;
            r_h     <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
            if (w_load && i_cmd.kind == K_HEADER) begin
                r_h   <= i_cmd.height[11:0];
                r_top <= i_cmd.top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= {3'b000, i_cmd.rgb, w_y, i_cmd.x, i_cmd.height, i_cmd.width,
                       i_cmd.code};
            r_user <= i_cmd.kind;
            r_last <= i_cmd.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;
    assign o_m_tlast  = r_last;

endmodule

// ===== rtl/core/bmp_stream_pixel_decoder.sv =====
// BMP byte stream decoder: header check, XRGB pixel output with row flip.
// Throughput: one file byte per cycle while the command queue is not full, set by the parser
// taking one byte each clock that it is not stalled. A result is written from the parser
// into the four-entry queue, then into the emitter's output register.
// Reset: synchronous active low; clears file length, position, parse phase and queue.
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // error_code[2:0], image_width[15:3], image_height[28:16], pixel_x[40:29],
    // pixel_y[52:41], pixel_rgb[76:53], zero[79:77]
    output logic [79:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);
    import bsd_pkg::*;

    logic w_accept;
    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_front_cmd;
    t_cmd w_q_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_full;
    assign w_accept    = i_s_tvalid && o_s_tready;

    bsd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_byte      (i_s_tdata),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd)
    );

    bsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    bsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_cmd      (w_q_cmd),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef ASSERT_OFF
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_last_on_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == K_PIXEL))
        else $error("tlast on a non-pixel result");

    a_code_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != K_ERROR) |-> (o_m_tdata[2:0] == 3'd0))
        else $error("error code set on a non-error result");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("emitter popped an empty queue");
`endif

endmodule
